// File: src/binomial_row_smoother_core_assert.svh
// assertion macros for the row smoother
`ifndef BINOMIAL_ROW_SMOOTHER_CORE_ASSERT_SVH
`define BINOMIAL_ROW_SMOOTHER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BRS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BRS_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRS_ASSERT(label, clk, rst, prop, msg)
`define BRS_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: src/brs_pkg.sv
// ----------------------------------------------------------------------------
// brs_pkg
// types, constants and arithmetic helpers of the row smoother
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package brs_pkg;
   localparam int MAX_ROW_DEF   = 1024;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CW            = 32;
   localparam int VW            = 3 * CW;
   localparam int NUMW          = 40;

   localparam logic [1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [1:0] REG_PASS_COUNT = 2'd1;
   localparam logic [1:0] REG_COMPENSATE = 2'd2;
   localparam logic [1:0] REG_WRAP_ENDS  = 2'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   typedef struct packed {
      logic          kind;
      logic [VW-1:0] vec;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_PASS_START, ST_PASS_LEFT, ST_RD_RIGHT, ST_WAIT_RIGHT,
      ST_CALC, ST_WB, ST_WRAP_A, ST_WRAP_B, ST_WRAP_C, ST_READ_A, ST_READ_B
   } state_type;

   function automatic logic signed [CW-1:0] quarter_round_sat(
      input logic signed [NUMW-1:0] num);
      logic signed [NUMW-1:0] q;
      q = (num + NUMW'(2)) >>> 2;
      if (q > NUMW'(signed'(32'sh7fffffff))) return 32'sh7fffffff;
      else if (q < -NUMW'(64'sd2147483648)) return 32'sh80000000;
      else return q[CW-1:0];
   endfunction
endpackage

// File: src/brs_ram.sv
// ----------------------------------------------------------------------------
// brs_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module brs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 1026
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wr_data;
      rd_data <= mem[addr];
   end
endmodule

// File: src/brs_front.sv
// ----------------------------------------------------------------------------
// brs_front
// two-entry item queue in front of the engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module brs_front
   import brs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  cmd_type req_cmd,
   output logic    q_valid,
   output cmd_type q_cmd,
   input  logic    q_pop
);
   cmd_type    slot_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff, push;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_cmd     = slot_ff[rd_ff];
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, q_pop && q_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (q_pop && q_valid) rd_ff <= !rd_ff;
      end
      if (push) slot_ff[wr_ff] <= req_cmd;
   end
endmodule

// File: src/brs_back.sv
// ----------------------------------------------------------------------------
// brs_back
// row store, pass sequencer and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module brs_back
   import brs_pkg::*;
#(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [10:0]           row_length,
   input  logic [3:0]            pass_count,
   input  logic                  compensate,
   input  logic                  wrap_ends,
   input  logic                  q_valid,
   input  cmd_type               q_cmd,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [CW-1:0]  rsp_out_x,
   output logic signed [CW-1:0]  rsp_out_y,
   output logic signed [CW-1:0]  rsp_out_z,
   output logic                  rsp_last_cell,
   output logic                  rsp_nothing_ready
);
   localparam int DEPTH = MAX_ROW + 2;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(MAX_ROW + 3);

   state_type state_ff, state_in;

   logic [IW-1:0] len;
   logic [IW-1:0] load_idx_ff, read_idx_ff, i_ff;
   logic [4:0]    pass_ff;
   logic          ready_ff;
   logic [VW-1:0] left_ff, centre_ff, right_ff, newv_ff, first_ff;
   logic          ov_ff;
   logic signed [CW-1:0] ox_ff, oy_ff, oz_ff;
   logic          olast_ff, onr_ff;

   logic          we;
   logic [AW-1:0] addr;
   logic [VW-1:0] wdata, rdata;
   logic          comp_pass;
   logic signed [5:0] ws;
   logic signed [6:0] wc;
   logic [VW-1:0] calc;
   logic          more_passes;
   logic [IW-1:0] ridx;

   brs_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(we), .addr(addr), .wr_data(wdata), .rd_data(rdata));

   always_comb begin
      if (row_length == 11'd0) len = IW'(1);
      else if (32'(row_length) > 32'(MAX_ROW)) len = IW'(MAX_ROW);
      else len = IW'(row_length);
   end

   assign comp_pass = (pass_ff == {1'b0, pass_count});
   assign ws = comp_pass ? -$signed({2'b0, pass_count}) : 6'sd1;
   assign wc = comp_pass ? 7'sd4 + $signed({2'b0, pass_count, 1'b0}) : 7'sd2;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         calc[k*CW +: CW] = quarter_round_sat(
            ws * NUMW'(signed'(left_ff[k*CW +: CW]))
            + wc * NUMW'(signed'(centre_ff[k*CW +: CW]))
            + ws * NUMW'(signed'(right_ff[k*CW +: CW])));
      end
   end

   assign more_passes = (pass_ff + 5'd1 < {1'b0, pass_count})
      || (pass_ff + 5'd1 == {1'b0, pass_count} && compensate && pass_count != 4'd0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (q_valid && !ov_ff) begin
               if (q_cmd.kind == KIND_LOAD) state_in = ST_LOAD;
               else if (ready_ff) state_in = ST_READ_A;
            end
         ST_LOAD:
            if (load_idx_ff + IW'(1) >= len + IW'(2))
               state_in = (pass_count != 4'd0) ? ST_PASS_START : ST_IDLE;
            else state_in = ST_IDLE;
         ST_PASS_START: state_in = ST_PASS_LEFT;
         ST_PASS_LEFT:  state_in = ST_RD_RIGHT;
         ST_RD_RIGHT:   state_in = ST_WAIT_RIGHT;
         ST_WAIT_RIGHT: state_in = ST_CALC;
         ST_CALC:       state_in = ST_WB;
         ST_WB:
            if (i_ff == len) state_in = wrap_ends ? ST_WRAP_A
               : (more_passes ? ST_PASS_START : ST_IDLE);
            else state_in = ST_RD_RIGHT;
         ST_WRAP_A: state_in = ST_WRAP_B;
         ST_WRAP_B: state_in = ST_WRAP_C;
         ST_WRAP_C: state_in = more_passes ? ST_PASS_START : ST_IDLE;
         ST_READ_A: state_in = ST_READ_B;
         ST_READ_B: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ram and queue control
   always_comb begin
      we    = 1'b0;
      addr  = '0;
      wdata = q_cmd.vec;
      q_pop = 1'b0;
      case (state_ff)
         ST_IDLE:
            if (q_valid && !ov_ff && q_cmd.kind == KIND_READ && !ready_ff) q_pop = 1'b1;
         ST_LOAD: begin
            q_pop = 1'b1;
            if (load_idx_ff < IW'(DEPTH)) we = 1'b1;
            addr = AW'(load_idx_ff);
         end
         ST_PASS_START: addr = AW'(0);
         ST_PASS_LEFT:  addr = AW'(1);
         ST_RD_RIGHT:   addr = AW'(i_ff + IW'(1));
         ST_WB: begin
            we = 1'b1;
            addr = AW'(i_ff);
            wdata = newv_ff;
         end
         ST_WRAP_A: addr = AW'(len);
         ST_WRAP_B: begin
            we = 1'b1;
            addr = AW'(0);
            wdata = rdata;
         end
         ST_WRAP_C: begin
            we = 1'b1;
            addr = AW'(len + IW'(1));
            wdata = first_ff;
         end
         ST_READ_A: begin
            q_pop = 1'b1;
            addr = AW'(((read_idx_ff > IW'(MAX_ROW - 1)) ? IW'(MAX_ROW - 1)
                        : read_idx_ff) + IW'(1));
         end
         default: ;
      endcase
   end

   assign ridx = (read_idx_ff > IW'(MAX_ROW - 1)) ? IW'(MAX_ROW - 1) : read_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         load_idx_ff <= '0;
         read_idx_ff <= '0;
         ready_ff    <= 1'b0;
         ov_ff       <= 1'b0;
         pass_ff     <= '0;
         i_ff        <= '0;
      end else begin
         state_ff <= state_in;
         if (ov_ff && !rsp_stall) ov_ff <= 1'b0;
         case (state_ff)
            ST_IDLE:
               if (q_valid && !ov_ff && q_cmd.kind == KIND_READ && !ready_ff) begin
                  ov_ff <= 1'b1;
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
                  olast_ff <= 1'b0; onr_ff <= 1'b1;
               end
            ST_LOAD:
               if (load_idx_ff + IW'(1) >= len + IW'(2)) begin
                  load_idx_ff <= '0;
                  read_idx_ff <= '0;
                  pass_ff <= '0;
                  ready_ff <= (pass_count == 4'd0);
               end else begin
                  load_idx_ff <= load_idx_ff + IW'(1);
                  ready_ff <= 1'b0;
               end
            ST_PASS_START: i_ff <= IW'(1);
            ST_PASS_LEFT:  left_ff <= rdata;
            ST_RD_RIGHT:
               if (i_ff == IW'(1)) centre_ff <= rdata;
            ST_WAIT_RIGHT: right_ff <= rdata;
            ST_CALC: newv_ff <= calc;
            ST_WB: begin
               left_ff   <= centre_ff;
               centre_ff <= right_ff;
               // new first interior cell, for the right ghost refresh
               if (i_ff == IW'(1)) first_ff <= newv_ff;
               i_ff <= i_ff + IW'(1);
               if (i_ff == len && !wrap_ends) begin
                  pass_ff <= pass_ff + 5'd1;
                  if (!more_passes) ready_ff <= 1'b1;
               end
            end
            ST_WRAP_B: ;
            ST_WRAP_C: begin
               pass_ff <= pass_ff + 5'd1;
               if (!more_passes) ready_ff <= 1'b1;
            end
            ST_READ_B: begin
               ov_ff <= 1'b1;
               ox_ff <= rdata[0 +: CW];
               oy_ff <= rdata[CW +: CW];
               oz_ff <= rdata[2*CW +: CW];
               onr_ff <= 1'b0;
               olast_ff <= (ridx + IW'(1) >= len);
               if (ridx + IW'(1) >= len) begin
                  ready_ff <= 1'b0;
                  read_idx_ff <= '0;
               end else read_idx_ff <= ridx + IW'(1);
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = ov_ff;
   assign rsp_out_x         = ox_ff;
   assign rsp_out_y         = oy_ff;
   assign rsp_out_z         = oz_ff;
   assign rsp_last_cell     = olast_ff;
   assign rsp_nothing_ready = onr_ff;
endmodule

// File: src/binomial_row_smoother_core.sv
// ----------------------------------------------------------------------------
// binomial_row_smoother_core
// multipass binomial row smoother with compensator pass
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | kind, cur_x/y/z
//  rsp     | out       | rsp_valid/rsp_stall  | out_x/y/z, last_cell, nothing_ready
//  csr     | in        | csr_write            | csr_index, csr_data
// a load item runs the idle and load states; a read item runs idle, read-a and read-b
// to the result register; the row completing runs each pass as pass-start, pass-left,
// then per cell rd-right, wait-right, calc and wb, then the wrap states if wrap ends is set;
// rate is set by the single port row memory; no item is taken while a result waits in the result register
// reset is synchronous; the row memory is not cleared
`timescale 1ns / 1ps
`include "binomial_row_smoother_core_assert.svh"
module binomial_row_smoother_core
   import brs_pkg::*;
#(
   parameter int MAX_ROW = MAX_ROW_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_kind,
   input  logic signed [CW-1:0] req_cur_x,
   input  logic signed [CW-1:0] req_cur_y,
   input  logic signed [CW-1:0] req_cur_z,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [CW-1:0] rsp_out_x,
   output logic signed [CW-1:0] rsp_out_y,
   output logic signed [CW-1:0] rsp_out_z,
   output logic                 rsp_last_cell,
   output logic                 rsp_nothing_ready,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [10:0]          csr_data
);
   logic [10:0] row_length_ff;
   logic [3:0]  pass_count_ff;
   logic        compensate_ff, wrap_ends_ff;
   logic        q_valid, q_pop;
   cmd_type     req_cmd, q_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= 11'd64;
         pass_count_ff <= 4'd1;
         compensate_ff <= 1'b0;
         wrap_ends_ff  <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROW_LENGTH: row_length_ff <= csr_data;
            REG_PASS_COUNT: pass_count_ff <= csr_data[3:0];
            REG_COMPENSATE: compensate_ff <= csr_data[0];
            REG_WRAP_ENDS:  wrap_ends_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign req_cmd.kind = req_kind;
   assign req_cmd.vec  = {req_cur_z, req_cur_y, req_cur_x};

   brs_front u_front (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_cmd(req_cmd), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop));

   brs_back #(.MAX_ROW(MAX_ROW)) u_back (
      .clock(clock), .reset(reset), .row_length(row_length_ff),
      .pass_count(pass_count_ff), .compensate(compensate_ff),
      .wrap_ends(wrap_ends_ff), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .rsp_last_cell(rsp_last_cell), .rsp_nothing_ready(rsp_nothing_ready));

   `BRS_ASSERT(a_nr_zero, clock, reset, rsp_valid && rsp_nothing_ready |-> rsp_out_x == 0 && !rsp_last_cell, "empty read result not zero")
   `BRS_ASSERT(a_nr_flags, clock, reset, rsp_valid |-> !(rsp_nothing_ready && rsp_last_cell), "both result flags set")
   `BRS_ASSERT(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x), "stalled result changed")
endmodule

// File: sim/binomial_row_smoother_core_tb.sv
// ----------------------------------------------------------------------------
// binomial_row_smoother_core_tb
// self-checking bench: rows of random cells are loaded and read back, and
// every read is compared against an in-bench model of the smoothing passes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module binomial_row_smoother_core_tb;
   import brs_pkg::*;

   localparam int DEPTH = MAX_ROW_DEF + 2;
   localparam longint LIMIT = 4000000;

   typedef struct {
      logic                 kind;
      logic signed [CW-1:0] x, y, z;
   } item_type;

   typedef struct {
      logic signed [CW-1:0] x, y, z;
      logic                 last, none;
   } result_type;

   logic                 clock = 1'b0, reset = 1'b1;
   logic                 req_valid = 1'b0, req_stall;
   logic                 req_kind = KIND_LOAD;
   logic signed [CW-1:0] req_cur_x = '0, req_cur_y = '0, req_cur_z = '0;
   logic                 rsp_valid, rsp_stall = 1'b0;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic                 rsp_last_cell, rsp_nothing_ready;
   logic                 csr_write = 1'b0;
   logic [1:0]           csr_index = REG_ROW_LENGTH;
   logic [10:0]          csr_data = '0;

   binomial_row_smoother_core u_top (.*);

   // smoother state as seen from outside
   int unsigned row_len = 64, passes = 1, comp_on = 0, wrap_on = 1;
   int          cells[0:DEPTH-1][3];
   int unsigned load_pos = 0, read_pos = 0;
   bit          rows_ready = 0;

   item_type    pending_q[$];
   result_type  smoothed_q[$];
   int          errors = 0, n_items = 0;
   int          idle_mode = 0;
   bit          hold_req = 0, hold_done = 0;
   int          hold_cnt = 0;
   longint      cycles = 0;
   item_type    nxt;
   result_type  exp_c;

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("binomial_row_smoother_core_tb: done, errors");
         $finish;
      end
   end

   function automatic int unsigned active_len();
      if (row_len < 1) return 1;
      if (row_len > MAX_ROW_DEF) return MAX_ROW_DEF;
      return row_len;
   endfunction

   function automatic int round_quarter(longint num);
      longint q;
      q = (num + 2) >>> 2;
      if (q > 64'sh7fffffff) q = 64'sh7fffffff;
      if (q < -64'sh80000000) q = -64'sh80000000;
      return int'(q);
   endfunction

   function automatic void smooth_pass(int unsigned len, longint ws, longint wc);
      int left[3];
      int mid[3];
      longint num;
      left = cells[0];
      for (int unsigned i = 1; i <= len; i++) begin
         mid = cells[i];
         for (int k = 0; k < 3; k++) begin
            num = ws * longint'(left[k]) + wc * longint'(mid[k])
                  + ws * longint'(cells[i+1][k]);
            cells[i][k] = round_quarter(num);
         end
         left = mid;
      end
      if (wrap_on != 0) begin
         cells[0] = cells[len];
         cells[len+1] = cells[1];
      end
   endfunction

   function automatic void accept_item(item_type it);
      int unsigned len, idx;
      result_type r;
      len = active_len();
      if (it.kind == KIND_LOAD) begin
         rows_ready = 0;
         if (load_pos < DEPTH) begin
            cells[load_pos][0] = it.x;
            cells[load_pos][1] = it.y;
            cells[load_pos][2] = it.z;
         end
         load_pos++;
         if (load_pos >= len + 2) begin
            for (int p = 0; p < passes; p++) smooth_pass(len, 1, 2);
            if (comp_on != 0 && passes >= 1)
               smooth_pass(len, -longint'(passes), 4 + 2 * longint'(passes));
            load_pos = 0;
            read_pos = 0;
            rows_ready = 1;
         end
      end else if (!rows_ready) begin
         r = '{0, 0, 0, 1'b0, 1'b1};
         smoothed_q.push_back(r);
      end else begin
         idx = read_pos;
         if (idx > MAX_ROW_DEF - 1) idx = MAX_ROW_DEF - 1;
         r.x = cells[idx+1][0];
         r.y = cells[idx+1][1];
         r.z = cells[idx+1][2];
         r.last = (idx + 1 >= len);
         r.none = 1'b0;
         smoothed_q.push_back(r);
         if (r.last) begin
            rows_ready = 0;
            read_pos = 0;
         end else begin
            read_pos = idx + 1;
         end
      end
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            accept_item('{req_kind, req_cur_x, req_cur_y, req_cur_z});
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 &&
                !(idle_mode == 0 && $urandom_range(0, 99) < 31) &&
                !(idle_mode == 1 && $urandom_range(0, 99) < 67)) begin
               nxt = pending_q.pop_front();
               req_valid <= 1'b1;
               req_kind  <= nxt.kind;
               req_cur_x <= nxt.x;
               req_cur_y <= nxt.y;
               req_cur_z <= nxt.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(posedge clock) begin
      if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt >= 3000) hold_done <= 1'b1;
      end else if (idle_mode == 0) begin
         rsp_stall <= ($urandom_range(0, 99) < 67);
      end else if (idle_mode == 1) begin
         rsp_stall <= ($urandom_range(0, 99) < 31);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (smoothed_q.size() == 0) begin
            $error("unexpected item on rsp");
            errors = errors + 1;
         end else begin
            exp_c = smoothed_q.pop_front();
            if (rsp_out_x !== exp_c.x) begin
               $error("out_x exp %0d got %0d", exp_c.x, rsp_out_x);
               errors = errors + 1;
            end
            if (rsp_out_y !== exp_c.y) begin
               $error("out_y exp %0d got %0d", exp_c.y, rsp_out_y);
               errors = errors + 1;
            end
            if (rsp_out_z !== exp_c.z) begin
               $error("out_z exp %0d got %0d", exp_c.z, rsp_out_z);
               errors = errors + 1;
            end
            if (rsp_last_cell !== exp_c.last) begin
               $error("last_cell exp %0d got %0d", exp_c.last, rsp_last_cell);
               errors = errors + 1;
            end
            if (rsp_nothing_ready !== exp_c.none) begin
               $error("nothing_ready exp %0d got %0d", exp_c.none, rsp_nothing_ready);
               errors = errors + 1;
            end
         end
      end
   end

   function automatic logic signed [CW-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_item(logic kind);
      item_type it;
      it.kind = kind;
      it.x = pick_value();
      it.y = pick_value();
      it.z = pick_value();
      pending_q.push_back(it);
      n_items++;
   endfunction

   // whole row of loads with some stray reads, then reads, possibly cut short
   function automatic void add_row(int unsigned len);
      int unsigned nread;
      for (int unsigned i = 0; i < len + 2; i++) begin
         if ($urandom_range(0, 9) == 0) add_item(KIND_READ);
         add_item(KIND_LOAD);
      end
      if ($urandom_range(0, 4) == 0) begin
         nread = $urandom_range(0, len - 1);
      end else begin
         nread = len + $urandom_range(0, 2);
      end
      repeat (nread) add_item(KIND_READ);
   endfunction

   function automatic void finish_row(int unsigned len);
      for (int unsigned i = 0; i < len + 2; i++) add_item(KIND_LOAD);
      repeat (len) add_item(KIND_READ);
   endfunction

   task automatic drain();
      while (pending_q.size() > 0 || req_valid || smoothed_q.size() > 0)
         @(posedge clock);
      repeat ((active_len() + 4) * 4 * (passes + 3) + 100) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[10:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_ROW_LENGTH: row_len = val & 11'h7ff;
         REG_PASS_COUNT: passes = val & 4'hf;
         REG_COMPENSATE: comp_on = val & 1;
         default:        wrap_on = val & 1;
      endcase
   endtask

   task automatic set_config(int unsigned len, int unsigned pc, int unsigned cp,
                             int unsigned wr);
      write_reg(REG_ROW_LENGTH, len);
      write_reg(REG_PASS_COUNT, pc);
      write_reg(REG_COMPENSATE, cp);
      write_reg(REG_WRAP_ENDS, wr);
   endtask

   initial begin
      int unsigned len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: read before any row, then a default row of 64
      add_item(KIND_READ);
      finish_row(64);
      drain();
      set_config(1, 0, 1, 0);
      finish_row(1);
      add_item(KIND_READ);
      drain();
      set_config(0, 15, 1, 1);
      finish_row(1);
      drain();
      set_config(3, 15, 1, 0);
      finish_row(3);
      drain();
      // over-long length, row left open and shortened by the next setup
      set_config(2047, 15, 1, 1);
      repeat (20) add_item(KIND_LOAD);
      add_item(KIND_READ);
      drain();

      // random phases
      while (n_items < 780 || !hold_req) begin
         idle_mode <= (n_items < 420) ? 0 : (n_items < 620) ? 1 : 2;
         len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         set_config(len, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                    : $urandom_range(0, 3),
                    $urandom_range(0, 1), $urandom_range(0, 1));
         if (!hold_req && n_items > 350) begin
            hold_req <= 1'b1;
            set_config(40, 2, 1, 1);
            finish_row(40);
            finish_row(40);
         end else begin
            repeat ($urandom_range(1, 4)) add_row(active_len());
            finish_row(active_len());
         end
         drain();
      end

      if (errors == 0 && smoothed_q.size() == 0)
         $display("binomial_row_smoother_core_tb: done, clean");
      else
         $display("binomial_row_smoother_core_tb: done, errors");
      $finish;
   end
endmodule
